FILE: rtl/core/thsu_pkg.sv
// Shared types and constants for the trilinear hysteresis stress update block.
// Depends on nothing; imported by every module under rtl/core.
package thsu_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int STRESS_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int Q_FRAC      = 30;

    // Products are saturated to plus or minus two to the power 32.
    localparam logic [33:0] WIDE_LIM = 34'h1_0000_0000;

    typedef enum logic [3:0] {
        PATH_ELASTIC  = 4'd0,
        PATH_YIELD1_P = 4'd1,
        PATH_YIELD2_P = 4'd2,
        PATH_UNLOAD_P = 4'd3,
        PATH_RECOV_P  = 4'd4,
        PATH_YIELD1_N = 4'd5,
        PATH_YIELD2_N = 4'd6,
        PATH_UNLOAD_N = 4'd7,
        PATH_RECOV_N  = 4'd8
    } t_path;

    typedef enum logic [2:0] {
        CFG_E0       = 3'd0,
        CFG_H1       = 3'd1,
        CFG_H2       = 3'd2,
        CFG_FY_SIG   = 3'd3,
        CFG_SY_SIG   = 3'd4,
        CFG_FY_EPS   = 3'd5,
        CFG_SY_EPS   = 3'd6,
        CFG_RESERVED = 3'd7
    } t_cfg_idx;

endpackage

FILE: rtl/core/thsu_mul.sv
// Bit-serial fixed-point multiplier: floor(m * d / 2^30), saturated to +-2^32.
// Depends on thsu_pkg; one operand bit is consumed per cycle.
module thsu_mul import thsu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic        [31:0] i_mult,
    input  logic signed [63:0] i_opnd,
    output logic               o_done,
    output logic signed [33:0] o_result
);

    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    logic        [5:0] r_cnt;
    logic              r_neg;
    logic       [31:0] r_m;
    logic       [31:0] r_acc;
    logic       [63:0] r_sh;
    logic signed [33:0] r_res;

    logic       [32:0] w_sum;
    logic              w_ovf;
    logic              w_inc;
    logic       [33:0] w_q;
    logic       [33:0] w_mag;

    always_comb begin
        w_sum = {1'b0, r_acc} + (r_sh[0] ? {1'b0, r_m} : 33'd0);
        w_ovf = |{r_acc, r_sh[63]};
        // Rounding toward minus infinity: a negative product with a fraction rounds away.
        w_inc = r_neg & (|r_sh[Q_FRAC-1:0]);
        w_q   = {1'b0, r_sh[62:Q_FRAC]} + {33'd0, w_inc};
        w_mag = (w_ovf || (w_q > WIDE_LIM)) ? WIDE_LIM : w_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_opnd[63];
                r_m    <= i_mult;
                r_acc  <= '0;
                r_sh   <= i_opnd[63] ? (64'd0 - 64'(i_opnd)) : 64'(i_opnd);
            end else if (r_busy) begin
                r_acc <= w_sum[32:1];
                r_sh  <= {w_sum[0], r_sh[63:1]};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_res  <= r_neg ? -signed'(w_mag) : signed'(w_mag);
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

FILE: rtl/core/thsu_div.sv
// Bit-serial restoring divider, quotient truncated toward zero, zero divisor gives zero.
// Depends on thsu_pkg; one quotient bit is produced per cycle.
module thsu_div import thsu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [32:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_quot
);

    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    logic        [5:0] r_cnt;
    logic              r_neg;
    logic       [31:0] r_dmag;
    logic       [31:0] r_rem;
    logic       [63:0] r_q;
    logic signed [63:0] r_res;

    logic       [32:0] w_shift;
    logic       [32:0] w_diff;
    logic              w_ge;
    logic       [32:0] w_dabs;

    always_comb begin
        w_shift = {r_rem, r_q[63]};
        w_diff  = w_shift - {1'b0, r_dmag};
        w_ge    = w_shift >= {1'b0, r_dmag};
        w_dabs  = i_den[32] ? (33'd0 - 33'(i_den)) : 33'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_num[63] ^ i_den[32];
                r_dmag <= w_dabs[31:0];
                r_rem  <= '0;
                r_q    <= i_num[63] ? (64'd0 - 64'(i_num)) : 64'(i_num);
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[31:0] : w_shift[31:0];
                r_q   <= {r_q[62:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                if (r_dmag == 32'd0) begin
                    r_res <= '0;
                end else begin
                    r_res <= r_neg ? -signed'(r_q) : signed'(r_q);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_res;

endmodule

FILE: rtl/core/trilinear_hysteresis_stress_update.sv
// Trilinear hysteretic stress update: top level with sequencer, history and result register.
// Depends on thsu_pkg, thsu_mul and thsu_div.
//
// Each beat on the input channel carries a trial strain (signed, 30 fraction bits) and a
// commit flag; each one produces exactly one result beat holding the stress, the tangent
// modulus and the path state. The block works on one beat at a time and holds o_in_stall
// high from acceptance until its result has been loaded into the output register; the
// output register then lets the next beat in while the result waits to be taken. All
// arithmetic runs through one bit-serial multiplier and one bit-serial divider. One
// operation step of the sequencer is a start state plus a wait state that ends on the
// unit's done pulse. A beat whose committed path is not an unload branch needs a single
// multiplication before its result. A beat following a committed unload branch first
// recomputes the reverse point (two divisions and three multiplications, one after
// another). A stall on the output holds the result step until the previous result
// has been taken. Only a beat with its commit flag set updates the committed strain,
// stress, path and extreme points; the reverse points are rewritten on every beat that
// follows a committed unload branch, whatever its commit flag. Configuration writes are
// taken whenever the write enable is high and must only be issued while the block is idle.
module trilinear_hysteresis_stress_update import thsu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic         [2:0] i_cfg_index,
    input  logic        [31:0] i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_trial_strain,
    input  logic               i_commit,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_stress,
    output logic        [31:0] o_tangent,
    output logic         [3:0] o_path_state
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV1, S_DIV1_W, S_MULA, S_MULA_W, S_MULB, S_MULB_W,
        S_DIV2, S_DIV2_W, S_MULC, S_MULC_W, S_PLAN, S_FIN, S_FIN_W, S_OUT
    } t_state;

    localparam logic signed [35:0] SIG_MAX = 36'((64'sd1 <<< (STRESS_BITS - 1)) - 64'sd1);
    localparam logic signed [35:0] SIG_MIN = -SIG_MAX - 36'sd1;
    localparam logic signed [35:0] WIDE_P  = 36'sd4294967296;
    localparam logic signed [35:0] WIDE_N  = -36'sd4294967296;

    function automatic logic signed [31:0] sat32_q(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    // Configuration registers.
    logic        [31:0] r_e0, r_h1, r_h2;
    logic        [30:0] r_fy_sig, r_sy_sig, r_fy_eps, r_sy_eps;

    // History.
    logic signed [31:0] r_cs_eps, r_cs_sig;
    t_path              r_cs_path;
    logic signed [31:0] r_pk_eps, r_pk_sig, r_tr_eps, r_tr_sig;
    logic signed [31:0] r_rp_eps, r_rp_sig, r_rn_eps, r_rn_sig;

    // Current beat and working values.
    t_state             r_state;
    logic signed [31:0] r_eps;
    logic               r_commit;
    logic signed [63:0] r_origin;
    logic signed [35:0] r_acc;
    logic signed [33:0] r_num;
    logic signed [31:0] r_re;
    t_path              r_fin_st;
    logic        [31:0] r_fin_m;
    logic signed [33:0] r_fin_d;
    logic signed [32:0] r_fin_base;

    // Output register.
    logic               r_out_valid;
    logic signed [31:0] r_stress;
    logic        [31:0] r_tangent;
    t_path              r_path;

    // Unit interfaces.
    logic               w_mul_start, w_div_start;
    logic        [31:0] w_mul_m;
    logic signed [63:0] w_mul_d;
    logic signed [63:0] w_div_n;
    logic signed [32:0] w_div_d;
    logic               w_mul_done, w_div_done;
    logic signed [33:0] w_mul_res;
    logic signed [63:0] w_div_q;

    logic               w_rev_neg;
    logic signed [31:0] w_pe, w_ps;
    logic signed [31:0] w_e1, w_e2;
    t_path              w_st;
    logic signed [33:0] w_e34;
    logic signed [35:0] w_sum;
    logic signed [31:0] w_sig;
    logic               w_out_free;

    thsu_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mult   (w_mul_m),
        .i_opnd   (w_mul_d),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    thsu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_n),
        .i_den   (w_div_d),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // The reverse point is taken toward the trough when unloading from the positive side,
    // and toward the peak when unloading from the negative side.
    assign w_rev_neg = (r_cs_path == PATH_UNLOAD_N);
    assign w_pe      = w_rev_neg ? r_pk_eps : r_tr_eps;
    assign w_ps      = w_rev_neg ? r_pk_sig : r_tr_sig;
    assign w_e1      = signed'({1'b0, r_fy_eps});
    assign w_e2      = signed'({1'b0, r_sy_eps});
    assign w_e34     = 34'(r_eps);

    always_comb begin
        w_mul_start = 1'b0;
        w_mul_m     = r_fin_m;
        w_mul_d     = 64'(r_fin_d);
        unique case (r_state)
            S_MULA: begin
                w_mul_start = 1'b1;
                w_mul_m     = r_e0;
                w_mul_d     = r_origin;
            end
            S_MULB: begin
                w_mul_start = 1'b1;
                w_mul_m     = r_h2;
                w_mul_d     = 64'(w_pe);
            end
            S_MULC: begin
                w_mul_start = 1'b1;
                w_mul_m     = r_e0;
                w_mul_d     = 64'(r_re) - r_origin;
            end
            S_FIN: begin
                w_mul_start = 1'b1;
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_div_start = (r_state == S_DIV1) || (r_state == S_DIV2);
        if (r_state == S_DIV2) begin
            w_div_n = {r_num, 30'd0};
            w_div_d = signed'({1'b0, r_e0}) - signed'({1'b0, r_h2});
        end else begin
            w_div_n = {{2{r_cs_sig[31]}}, r_cs_sig, 30'd0};
            w_div_d = signed'({1'b0, r_e0});
        end
    end

    // Branch selection from the committed path and the freshly stored reverse points.
    // A large step across several branches is taken as one branch change only.
    always_comb begin
        unique case (r_cs_path)
            PATH_YIELD1_P: begin
                w_st = (r_eps < r_cs_eps) ? PATH_UNLOAD_P
                     : (r_eps > w_e2) ? PATH_YIELD2_P : PATH_YIELD1_P;
            end
            PATH_YIELD2_P: begin
                w_st = (r_eps < r_cs_eps) ? PATH_UNLOAD_P : PATH_YIELD2_P;
            end
            PATH_UNLOAD_P: begin
                if (r_eps > r_cs_eps) begin
                    w_st = (r_eps > w_e2) ? PATH_YIELD2_P : PATH_YIELD1_P;
                end else begin
                    w_st = (r_eps < r_rp_eps) ? PATH_RECOV_P : PATH_UNLOAD_P;
                end
            end
            PATH_RECOV_P: begin
                if (r_eps > r_cs_eps) begin
                    w_st = (r_eps < -w_e1) ? PATH_UNLOAD_N : PATH_UNLOAD_P;
                end else if (r_eps < r_tr_eps && r_eps < -w_e2) begin
                    w_st = PATH_YIELD2_N;
                end else if (r_eps < r_tr_eps && r_eps < -w_e1) begin
                    w_st = PATH_YIELD1_N;
                end else begin
                    w_st = PATH_RECOV_P;
                end
            end
            PATH_YIELD1_N: begin
                w_st = (r_eps > r_cs_eps) ? PATH_UNLOAD_N
                     : (r_eps < -w_e2) ? PATH_YIELD2_N : PATH_YIELD1_N;
            end
            PATH_YIELD2_N: begin
                w_st = (r_eps > r_cs_eps) ? PATH_UNLOAD_N : PATH_YIELD2_N;
            end
            PATH_UNLOAD_N: begin
                if (r_eps < r_cs_eps) begin
                    w_st = (r_eps < -w_e2) ? PATH_YIELD2_N : PATH_YIELD1_N;
                end else begin
                    w_st = (r_eps > r_rn_eps) ? PATH_RECOV_N : PATH_UNLOAD_N;
                end
            end
            PATH_RECOV_N: begin
                if (r_eps < r_cs_eps) begin
                    w_st = (r_eps > w_e1) ? PATH_UNLOAD_P : PATH_UNLOAD_N;
                end else if (r_eps > r_pk_eps && r_eps > w_e2) begin
                    w_st = PATH_YIELD2_P;
                end else if (r_eps > r_pk_eps && r_eps > w_e1) begin
                    w_st = PATH_YIELD1_P;
                end else begin
                    w_st = PATH_RECOV_N;
                end
            end
            default: begin
                if (r_eps > 32'sd0) begin
                    w_st = (r_eps > w_e2) ? PATH_YIELD2_P
                         : (r_eps > w_e1) ? PATH_YIELD1_P : PATH_ELASTIC;
                end else begin
                    w_st = (r_eps < -w_e2) ? PATH_YIELD2_N
                         : (r_eps < -w_e1) ? PATH_YIELD1_N : PATH_ELASTIC;
                end
            end
        endcase
    end

    assign w_sum = 36'(r_fin_base) + 36'(w_mul_res);
    assign w_sig = (w_sum > SIG_MAX) ? SIG_MAX[31:0]
                 : (w_sum < SIG_MIN) ? SIG_MIN[31:0] : w_sum[31:0];
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_e0        <= 32'd1;
            r_h1        <= '0;
            r_h2        <= '0;
            r_fy_sig    <= '0;
            r_sy_sig    <= '0;
            r_fy_eps    <= '0;
            r_sy_eps    <= '0;
            r_cs_eps    <= '0;
            r_cs_sig    <= '0;
            r_cs_path   <= PATH_ELASTIC;
            r_pk_eps    <= '0;
            r_pk_sig    <= '0;
            r_tr_eps    <= '0;
            r_tr_sig    <= '0;
            r_rp_eps    <= '0;
            r_rp_sig    <= '0;
            r_rn_eps    <= '0;
            r_rn_sig    <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_E0:     r_e0     <= i_cfg_data;
                    CFG_H1:     r_h1     <= i_cfg_data;
                    CFG_H2:     r_h2     <= i_cfg_data;
                    CFG_FY_SIG: begin
                        r_fy_sig <= i_cfg_data[30:0];
                        r_pk_sig <= signed'({1'b0, i_cfg_data[30:0]});
                        r_tr_sig <= -signed'({1'b0, i_cfg_data[30:0]});
                    end
                    CFG_SY_SIG: r_sy_sig <= i_cfg_data[30:0];
                    CFG_FY_EPS: begin
                        r_fy_eps <= i_cfg_data[30:0];
                        r_pk_eps <= signed'({1'b0, i_cfg_data[30:0]});
                        r_tr_eps <= -signed'({1'b0, i_cfg_data[30:0]});
                    end
                    CFG_SY_EPS: r_sy_eps <= i_cfg_data[30:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_eps    <= i_trial_strain;
                        r_commit <= i_commit;
                        if (r_cs_path == PATH_UNLOAD_P || r_cs_path == PATH_UNLOAD_N) begin
                            r_state <= S_DIV1;
                        end else begin
                            r_state <= S_PLAN;
                        end
                    end
                end
                S_DIV1: r_state <= S_DIV1_W;
                S_DIV1_W: begin
                    if (w_div_done) begin
                        // Strain at which the elastic unload line crosses zero stress.
                        r_origin <= 64'(r_cs_eps) - w_div_q;
                        r_state  <= S_MULA;
                    end
                end
                S_MULA: r_state <= S_MULA_W;
                S_MULA_W: begin
                    if (w_mul_done) begin
                        r_acc   <= 36'(w_mul_res) + 36'(w_ps);
                        r_state <= S_MULB;
                    end
                end
                S_MULB: r_state <= S_MULB_W;
                S_MULB_W: begin
                    if (w_mul_done) begin
                        if (r_acc - 36'(w_mul_res) > WIDE_P) begin
                            r_num <= WIDE_P[33:0];
                        end else if (r_acc - 36'(w_mul_res) < WIDE_N) begin
                            r_num <= WIDE_N[33:0];
                        end else begin
                            r_num <= 34'(r_acc - 36'(w_mul_res));
                        end
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: r_state <= S_DIV2_W;
                S_DIV2_W: begin
                    if (w_div_done) begin
                        r_re    <= sat32_q(w_div_q);
                        r_state <= S_MULC;
                    end
                end
                S_MULC: r_state <= S_MULC_W;
                S_MULC_W: begin
                    if (w_mul_done) begin
                        if (w_rev_neg) begin
                            r_rn_eps <= r_re;
                            r_rn_sig <= sat32_q(64'(w_mul_res));
                        end else begin
                            r_rp_eps <= r_re;
                            r_rp_sig <= sat32_q(64'(w_mul_res));
                        end
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    r_fin_st <= w_st;
                    unique case (w_st)
                        PATH_YIELD1_P: begin
                            r_fin_m    <= r_h1;
                            r_fin_d    <= w_e34 - 34'(w_e1);
                            r_fin_base <= 33'(signed'({1'b0, r_fy_sig}));
                        end
                        PATH_YIELD2_P: begin
                            r_fin_m    <= r_h2;
                            r_fin_d    <= w_e34 - 34'(w_e2);
                            r_fin_base <= 33'(signed'({1'b0, r_sy_sig}));
                        end
                        PATH_YIELD1_N: begin
                            r_fin_m    <= r_h1;
                            r_fin_d    <= w_e34 + 34'(w_e1);
                            r_fin_base <= -33'(signed'({1'b0, r_fy_sig}));
                        end
                        PATH_YIELD2_N: begin
                            r_fin_m    <= r_h2;
                            r_fin_d    <= w_e34 + 34'(w_e2);
                            r_fin_base <= -33'(signed'({1'b0, r_sy_sig}));
                        end
                        PATH_UNLOAD_P, PATH_UNLOAD_N: begin
                            r_fin_m    <= r_e0;
                            r_fin_d    <= w_e34 - 34'(r_cs_eps);
                            r_fin_base <= 33'(r_cs_sig);
                        end
                        PATH_RECOV_P: begin
                            r_fin_m    <= r_h2;
                            r_fin_d    <= w_e34 - 34'(r_rp_eps);
                            r_fin_base <= 33'(r_rp_sig);
                        end
                        PATH_RECOV_N: begin
                            r_fin_m    <= r_h2;
                            r_fin_d    <= w_e34 - 34'(r_rn_eps);
                            r_fin_base <= 33'(r_rn_sig);
                        end
                        default: begin
                            r_fin_m    <= r_e0;
                            r_fin_d    <= w_e34;
                            r_fin_base <= '0;
                        end
                    endcase
                    r_state <= S_FIN;
                end
                S_FIN: r_state <= S_FIN_W;
                S_FIN_W: begin
                    if (w_mul_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_stress    <= w_sig;
                        r_tangent   <= r_fin_m;
                        r_path      <= r_fin_st;
                        if (r_commit) begin
                            r_cs_eps  <= r_eps;
                            r_cs_sig  <= w_sig;
                            r_cs_path <= r_fin_st;
                            if ((r_fin_st == PATH_YIELD1_P || r_fin_st == PATH_YIELD2_P)
                                && r_eps > r_pk_eps) begin
                                r_pk_eps <= r_eps;
                                r_pk_sig <= w_sig;
                            end
                            if ((r_fin_st == PATH_YIELD1_N || r_fin_st == PATH_YIELD2_N)
                                && r_eps < r_tr_eps) begin
                                r_tr_eps <= r_eps;
                                r_tr_sig <= w_sig;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_stress     = r_stress;
    assign o_tangent    = r_tangent;
    assign o_path_state = r_path;

endmodule
